FILE: src/isort_pkg.sv
// Package for the insertion sorter: sizes, controller states and the
// command/status structs between controller and datapath. No dependencies.
package isort_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic insert;
    logic shift;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic last_one;
  } status_t;

endpackage

FILE: src/isort_ctrl.sv
// Controller of the insertion sorter: load/emit state machine.
// Depends on isort_pkg.
module isort_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             last_i,
  input  isort_pkg::status_t status_i,
  output isort_pkg::cmd_t  cmd_o,
  output logic             busy,
  output logic             strobe_o,
  output logic             final_res_o
);
  import isort_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (start && last_i) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.last_one) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    busy        = 1'b0;
    strobe_o    = 1'b0;
    final_res_o = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        cmd_o.insert = start;
      end
      ST_EMIT: begin
        busy        = 1'b1;
        strobe_o    = 1'b1;
        final_res_o = status_i.last_one;
        cmd_o.shift = 1'b1;
        cmd_o.clear = status_i.last_one;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

FILE: src/isort_dp.sv
// Datapath of the insertion sorter: a row of compare-and-shift cells,
// fill count and drop flag. Depends on isort_pkg.
module isort_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  isort_pkg::cmd_t                     cmd_i,
  input  logic signed [isort_pkg::DATA_W-1:0] value_i,
  output isort_pkg::status_t                  status_o,
  output logic signed [isort_pkg::DATA_W-1:0] head_o,
  output logic                                dropped_o
);
  import isort_pkg::*;

  logic signed [DATA_W-1:0] cell_q [CAPACITY];
  logic signed [DATA_W-1:0] cell_d [CAPACITY];
  logic [CAPACITY-1:0]      gt;
  logic [CNT_W-1:0]         count_q, count_d;
  logic                     dropped_q, dropped_d;
  logic                     full;

  assign full = (count_q == CNT_W'(CAPACITY));

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign gt[i] = (CNT_W'(i) < count_q) && (cell_q[i] > value_i);

    if (i == 0) begin : g_first
      always_comb begin
        cell_d[i] = cell_q[i];
        if (cmd_i.shift) begin
          cell_d[i] = cell_q[i+1];
        end else if (cmd_i.insert && !full) begin
          if (gt[i] || (CNT_W'(i) == count_q)) begin
            cell_d[i] = value_i;
          end
        end
      end
    end else if (i == CAPACITY - 1) begin : g_top
      always_comb begin
        cell_d[i] = cell_q[i];
        if (cmd_i.insert && !full && !cmd_i.shift) begin
          if (gt[i-1]) begin
            cell_d[i] = cell_q[i-1];
          end else if (gt[i] || (CNT_W'(i) == count_q)) begin
            cell_d[i] = value_i;
          end
        end
      end
    end else begin : g_mid
      always_comb begin
        cell_d[i] = cell_q[i];
        if (cmd_i.shift) begin
          cell_d[i] = cell_q[i+1];
        end else if (cmd_i.insert && !full) begin
          if (gt[i-1]) begin
            cell_d[i] = cell_q[i-1];
          end else if (gt[i] || (CNT_W'(i) == count_q)) begin
            cell_d[i] = value_i;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      cell_q[i] <= cell_d[i];
    end
  end

  always_comb begin
    count_d   = count_q;
    dropped_d = dropped_q;
    if (cmd_i.shift) begin
      count_d = count_q - CNT_W'(1);
    end else if (cmd_i.insert) begin
      if (full) begin
        dropped_d = 1'b1;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end
    if (cmd_i.clear) begin
      dropped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      dropped_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      dropped_q <= dropped_d;
    end
  end

  assign status_o.last_one = (count_q == CNT_W'(1));
  assign head_o            = cell_q[0];
  assign dropped_o         = dropped_q;

endmodule

FILE: src/insertion_sorter.sv
// Top level of the insertion sorter: controller plus cell-row datapath.
// Depends on isort_pkg, isort_ctrl and isort_dp.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------------------
//   input    | start, busy        | value_i, last_i
//   result   | strobe_o           | sorted_value_o, final_res_o, overflow_o
//
// An item is inserted in the cycle it is accepted: every cell compares in
// parallel, so one item per cycle while busy is low.
// A last item starts a burst of one result per cycle, one per stored entry
// (1 to CAPACITY entries), read off the bottom cell while the row shifts down.
// busy is high for the burst; results cannot be stalled.
// Reset clears the count and the drop flag; the cells need no clearing.
module insertion_sorter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [isort_pkg::DATA_W-1:0] value_i,
  input  logic                                last_i,
  output logic                                strobe_o,
  output logic signed [isort_pkg::DATA_W-1:0] sorted_value_o,
  output logic                                final_res_o,
  output logic                                overflow_o
);
  import isort_pkg::*;

  cmd_t    cmd;
  status_t status;

  isort_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .last_i      (last_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .busy        (busy),
    .strobe_o    (strobe_o),
    .final_res_o (final_res_o)
  );

  isort_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .value_i   (value_i),
    .status_o  (status),
    .head_o    (sorted_value_o),
    .dropped_o (overflow_o)
  );

endmodule

FILE: src/isort_checker.sv
// Port-level checker for the insertion sorter, bound to the top level.
// Depends on insertion_sorter.
module isort_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start,
  input logic                                busy,
  input logic                                last_i,
  input logic                                strobe_o,
  input logic                                final_res_o,
  input logic                                overflow_o
);

  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> busy) else $error("result outside busy");

  a_final_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    final_res_o |-> strobe_o) else $error("final without strobe");

  a_final_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && final_res_o |=> !strobe_o && !busy) else $error("burst overran");

  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && last_i |=> strobe_o) else $error("no burst after last");

  a_burst_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !final_res_o |=> strobe_o && $stable(overflow_o))
    else $error("burst broken");

endmodule

bind insertion_sorter isort_checker u_isort_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .last_i      (last_i),
  .strobe_o    (strobe_o),
  .final_res_o (final_res_o),
  .overflow_o  (overflow_o)
);
